>>> src/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB converter pipeline.
package hsv2rgb_pkg;

    localparam int HUE_W   = 16;
    localparam int CHAN_W  = 8;
    localparam int WHEEL_W = 11;
    localparam int PROD_W  = 27;

    localparam logic [WHEEL_W-1:0] WHEEL_STEPS = 11'd1530;
    localparam logic [PROD_W-1:0]  HUE_ROUND   = 27'd32768;
    localparam logic [WHEEL_W-1:0] SLICE_1     = 11'd255;
    localparam logic [WHEEL_W-1:0] SLICE_2     = 11'd510;
    localparam logic [WHEEL_W-1:0] SLICE_3     = 11'd765;
    localparam logic [WHEEL_W-1:0] SLICE_4     = 11'd1020;
    localparam logic [WHEEL_W-1:0] SLICE_5     = 11'd1275;
    localparam logic [CHAN_W-1:0]  CHAN_FULL   = 8'd255;
    localparam logic [CHAN_W-1:0]  CHAN_ZERO   = 8'd0;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [WHEEL_W-1:0] wheel_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } rgb_t;

endpackage

>>> src/hsv2rgb_hue_scale.sv
// First stage: maps the 16-bit hue onto the 0..1530 wheel with rounding.
module hsv2rgb_hue_scale
    import hsv2rgb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [HUE_W-1:0]    hue_angle,
    input  chan_t               saturation,
    input  chan_t               brightness_level,
    output logic                out_valid,
    input  logic                out_ready,
    output wheel_t              wheel,
    output chan_t               sat,
    output chan_t               val
);

    logic               valid_reg;
    wheel_t             wheel_reg;
    wheel_t             wheel_next;
    chan_t              sat_reg;
    chan_t              val_reg;
    logic [PROD_W-1:0]  prod;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        prod       = PROD_W'(hue_angle) * PROD_W'(WHEEL_STEPS) + HUE_ROUND;
        wheel_next = prod[PROD_W-1:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            wheel_reg <= wheel_next;
            sat_reg   <= saturation;
            val_reg   <= brightness_level;
        end
    end

    assign out_valid = valid_reg;
    assign wheel     = wheel_reg;
    assign sat       = sat_reg;
    assign val       = val_reg;

endmodule

>>> src/hsv2rgb_hexcone.sv
// Second stage: picks the hexcone slice and forms the pure color.
module hsv2rgb_hexcone
    import hsv2rgb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  wheel_t  wheel,
    input  chan_t   sat_in,
    input  chan_t   val_in,
    output logic    out_valid,
    input  logic    out_ready,
    output rgb_t    pure_rgb,
    output chan_t   sat,
    output chan_t   val
);

    logic   valid_reg;
    rgb_t   pure_reg;
    rgb_t   pure_next;
    chan_t  sat_reg;
    chan_t  val_reg;
    wheel_t diff;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        pure_next = '{r: CHAN_FULL, g: CHAN_ZERO, b: CHAN_ZERO};
        diff      = '0;
        priority if (wheel < SLICE_1)
        begin
            pure_next = '{r: CHAN_FULL, g: wheel[CHAN_W-1:0], b: CHAN_ZERO};
        end
        else if (wheel < SLICE_2)
        begin
            diff      = SLICE_2 - wheel;
            pure_next = '{r: diff[CHAN_W-1:0], g: CHAN_FULL, b: CHAN_ZERO};
        end
        else if (wheel < SLICE_3)
        begin
            diff      = wheel - SLICE_2;
            pure_next = '{r: CHAN_ZERO, g: CHAN_FULL, b: diff[CHAN_W-1:0]};
        end
        else if (wheel < SLICE_4)
        begin
            diff      = SLICE_4 - wheel;
            pure_next = '{r: CHAN_ZERO, g: diff[CHAN_W-1:0], b: CHAN_FULL};
        end
        else if (wheel < SLICE_5)
        begin
            diff      = wheel - SLICE_4;
            pure_next = '{r: diff[CHAN_W-1:0], g: CHAN_ZERO, b: CHAN_FULL};
        end
        else if (wheel < WHEEL_STEPS)
        begin
            diff      = WHEEL_STEPS - wheel;
            pure_next = '{r: CHAN_FULL, g: CHAN_ZERO, b: diff[CHAN_W-1:0]};
        end
        else
        begin
            // The top of the wheel wraps back to pure red.
            pure_next = '{r: CHAN_FULL, g: CHAN_ZERO, b: CHAN_ZERO};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pure_reg <= pure_next;
            sat_reg  <= sat_in;
            val_reg  <= val_in;
        end
    end

    assign out_valid = valid_reg;
    assign pure_rgb  = pure_reg;
    assign sat       = sat_reg;
    assign val       = val_reg;

endmodule

>>> src/hsv2rgb_shade.sv
// Third and fourth stages: saturation blend, then brightness scaling, per channel.
module hsv2rgb_shade
    import hsv2rgb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  rgb_t    pure_rgb,
    input  chan_t   sat,
    input  chan_t   val,
    output logic    out_valid,
    input  logic    out_ready,
    output rgb_t    color
);

    localparam int MIX_W  = CHAN_W + 1;
    localparam int PSAT_W = 2 * CHAN_W + 1;
    localparam int PVAL_W = 2 * MIX_W;

    logic               valid_a_reg;
    logic               valid_b_reg;
    logic               ready_a;
    logic               ready_b;
    logic [MIX_W-1:0]   mix_reg  [3];
    logic [MIX_W-1:0]   mix_next [3];
    chan_t              val_reg;
    rgb_t               color_reg;
    rgb_t               color_next;
    chan_t              pure_ch  [3];
    logic [PSAT_W-1:0]  psat     [3];
    logic [PVAL_W-1:0]  pval     [3];
    logic [MIX_W-1:0]   sat_inc;
    logic [MIX_W-1:0]   val_inc;

    assign ready_b  = !valid_b_reg || out_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    assign pure_ch[0] = pure_rgb.r;
    assign pure_ch[1] = pure_rgb.g;
    assign pure_ch[2] = pure_rgb.b;

    // Blend toward white: (c * (sat + 1)) >> 8 plus the grey floor 255 - sat.
    always_comb
    begin
        sat_inc = MIX_W'(sat) + MIX_W'(1);
        for (int i = 0; i < 3; i++)
        begin
            psat[i]     = PSAT_W'(pure_ch[i]) * PSAT_W'(sat_inc);
            mix_next[i] = MIX_W'(psat[i][PSAT_W-1:CHAN_W]) + MIX_W'(CHAN_FULL - sat);
        end
    end

    // Brightness scaling keeps bits 15..8 of the product.
    always_comb
    begin
        val_inc = MIX_W'(val_reg) + MIX_W'(1);
        for (int i = 0; i < 3; i++)
        begin
            pval[i] = PVAL_W'(mix_reg[i]) * PVAL_W'(val_inc);
        end
        color_next.r = pval[0][2*CHAN_W-1:CHAN_W];
        color_next.g = pval[1][2*CHAN_W-1:CHAN_W];
        color_next.b = pval[2][2*CHAN_W-1:CHAN_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            mix_reg <= mix_next;
            val_reg <= val;
        end
        if (ready_b && valid_a_reg)
        begin
            color_reg <= color_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign color     = color_reg;

endmodule

>>> src/hsv_to_rgb_converter.sv
// An accepted item reaches red, green and blue through the four register stages below.
// Throughput: one item per cycle unless the output stalls; each of the four register
// stages holds one item and has its own valid bit, so a stall backs up stage by stage.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
// Stages: hue scaling multiply, hexcone slice select, saturation blend multiply,
// brightness multiply.
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [HUE_W-1:0]    hue_angle,
    input  logic [CHAN_W-1:0]   saturation,
    input  logic [CHAN_W-1:0]   brightness_level,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CHAN_W-1:0]   red,
    output logic [CHAN_W-1:0]   green,
    output logic [CHAN_W-1:0]   blue
);

    // Handshake between the hue stage and the hexcone stage.
    logic   hue_valid;
    logic   hue_ready;
    wheel_t hue_wheel;
    chan_t  hue_sat;
    chan_t  hue_val;

    // Handshake between the hexcone stage and the shading stages.
    logic   hex_valid;
    logic   hex_ready;
    rgb_t   hex_pure;
    chan_t  hex_sat;
    chan_t  hex_val;

    rgb_t   color;

    // The hue is rounded onto a 1530-step wheel, six slices of 255 steps each.
    hsv2rgb_hue_scale u_hue_scale (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .hue_angle        (hue_angle),
        .saturation       (saturation),
        .brightness_level (brightness_level),
        .out_valid        (hue_valid),
        .out_ready        (hue_ready),
        .wheel            (hue_wheel),
        .sat              (hue_sat),
        .val              (hue_val)
    );

    // Each slice ramps one primary up or down while the other two sit at full or zero.
    hsv2rgb_hexcone u_hexcone (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hue_valid),
        .in_ready  (hue_ready),
        .wheel     (hue_wheel),
        .sat_in    (hue_sat),
        .val_in    (hue_val),
        .out_valid (hex_valid),
        .out_ready (hex_ready),
        .pure_rgb  (hex_pure),
        .sat       (hex_sat),
        .val       (hex_val)
    );

    // The pure color is blended toward white by saturation and then scaled by
    // brightness. The last register of this unit is the output register.
    hsv2rgb_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hex_valid),
        .in_ready  (hex_ready),
        .pure_rgb  (hex_pure),
        .sat       (hex_sat),
        .val       (hex_val),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .color     (color)
    );

    assign red   = color.r;
    assign green = color.g;
    assign blue  = color.b;

endmodule
